FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the order book matcher.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

FILE: hdl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Types, codes and defaults shared by the order book matcher modules.
// ----------------------------------------------------------------------------
package lobm_pkg;

   localparam int PRICE_LEVELS_DEF = 1024;
   localparam int ORDER_SLOTS_DEF  = 1024;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_MATCH = 1'b1;

   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_WRONG    = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_TRADE    = 3'd3;
   localparam logic [2:0] ST_NO_CROSS = 3'd4;

   typedef struct packed {
      logic        cmd;
      logic [15:0] order_symbol;
      logic        side;
      logic [9:0]  price_tick;
      logic [31:0] quantity;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] trade_qty;
      logic        bid_valid;
      logic [9:0]  best_bid;
      logic        ask_valid;
      logic [9:0]  best_ask;
      logic [39:0] bid_liquidity;
      logic [39:0] ask_liquidity;
   } rsp_type;

   // operation on one side's occupancy bitmap
   typedef struct packed {
      logic set;
      logic clr;
      logic search;
   } bm_op_type;

endpackage

FILE: hdl/lobm_ram.sv
// ----------------------------------------------------------------------------
// lobm_ram
// Simple dual-port synchronous RAM, registered read with read enable.
// ----------------------------------------------------------------------------
module lobm_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

FILE: hdl/lobm_best.sv
// ----------------------------------------------------------------------------
// lobm_best
// Two-level occupancy bitmap of one book side: a row memory of 32-bit words
// and a summary bit per row. Sets and clears levels, finds the best level.
// ----------------------------------------------------------------------------
module lobm_best #(
   parameter int PRICE_LEVELS = lobm_pkg::PRICE_LEVELS_DEF,
   parameter bit HIGHEST      = 1'b1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lobm_pkg::bm_op_type             op_i,
   input  logic [$clog2(PRICE_LEVELS)-1:0] tick_i,
   output logic                            occ_o,
   output logic                            found_o,
   output logic [$clog2(PRICE_LEVELS)-1:0] best_o
);

   localparam int LW   = $clog2(PRICE_LEVELS);
   localparam int ROWS = (PRICE_LEVELS + 31) / 32;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [31:0]         row_mem [ROWS];
   logic [ROWS-1:0]     summary_ff, summary_in;
   logic [31:0]         rd_ff;
   lobm_pkg::bm_op_type op_ff;
   logic [RW-1:0]       row_ff;
   logic [4:0]          bit_ff;
   logic                found_ff;

   logic [RW-1:0] pick_row;
   logic          pick_any;
   logic [RW-1:0] rd_row;
   logic [31:0]   row_data;
   logic [31:0]   row_new;
   logic [4:0]    pick_bit;
   logic          op_any;

   // best non-empty row from the summary
   always_comb begin
      pick_row = '0;
      pick_any = 1'b0;
      for (int i = 0; i < ROWS; i++) begin
         if (summary_ff[HIGHEST ? i : ROWS - 1 - i]) begin
            pick_row = RW'(HIGHEST ? i : ROWS - 1 - i);
            pick_any = 1'b1;
         end
      end
   end

   assign op_any   = op_i.set | op_i.clr | op_i.search;
   assign rd_row   = op_i.search ? pick_row : RW'(tick_i >> 5);
   assign row_data = summary_ff[row_ff] ? rd_ff : '0;
   assign row_new  = op_ff.set ? (row_data | (32'd1 << bit_ff))
                               : (row_data & ~(32'd1 << bit_ff));

   // best bit within the fetched row
   always_comb begin
      pick_bit = '0;
      for (int i = 0; i < 32; i++) begin
         if (row_data[HIGHEST ? i : 31 - i]) begin
            pick_bit = 5'(HIGHEST ? i : 31 - i);
         end
      end
   end

   always_comb begin
      summary_in = summary_ff;
      if (op_ff.set || op_ff.clr) begin
         summary_in[row_ff] = |row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (op_any) begin
         rd_ff <= row_mem[rd_row];
      end
      if (op_ff.set || op_ff.clr) begin
         row_mem[row_ff] <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff      <= '0;
         summary_ff <= '0;
      end else begin
         op_ff      <= op_i;
         summary_ff <= summary_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_any) begin
         row_ff   <= rd_row;
         bit_ff   <= 5'(tick_i);
         found_ff <= pick_any;
      end
   end

   assign occ_o   = row_data[bit_ff];
   assign found_o = found_ff;
   assign best_o  = LW'({row_ff, pick_bit});

endmodule

FILE: hdl/limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Single-symbol limit order book with price-time priority.
// ----------------------------------------------------------------------------
// One request at a time. An add passes through level and free-list read,
// write-back, best-level total read and result register; a rejected add or
// a match with no cross skips the first two; a trade reads both front
// orders, writes back the fill, releases spent slots and searches for a new
// best when a level empties. Memory reads are registered: the two front
// orders are fetched one after the other through the single read port of
// the slot memories, and a best-level search costs a summary pick plus a
// row read in the bitmap memory. Slots are handed out first from a fill
// counter and then from a free list, so no clearing pass follows reset. A
// finished result waits in the output register while the next request is
// taken in; csr_ready is high whenever no request is in progress.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module limit_order_book_matcher #(
   parameter int PRICE_LEVELS = lobm_pkg::PRICE_LEVELS_DEF,
   parameter int ORDER_SLOTS  = lobm_pkg::ORDER_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lobm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lobm_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);

   localparam int LW  = $clog2(PRICE_LEVELS);
   localparam int SW  = $clog2(ORDER_SLOTS);
   localparam int SCW = $clog2(ORDER_SLOTS + 1);

   typedef struct packed {
      logic [SW-1:0] head;
      logic [SW-1:0] tail;
      logic [39:0]   total;
   } lvl_type;

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_ADD  = 10'b0000000010,
      S_MT1  = 10'b0000000100,
      S_MT2  = 10'b0000001000,
      S_MT3  = 10'b0000010000,
      S_MT4  = 10'b0000100000,
      S_SRCH = 10'b0001000000,
      S_SRES = 10'b0010000000,
      S_ORD  = 10'b0100000000,
      S_OUT  = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   lobm_pkg::req_type req_ff, req_in;
   logic [2:0]        status_ff, status_in;
   logic [31:0]       trade_ff, trade_in;
   logic [31:0]       bq_ff, bq_in;
   logic [SW-1:0]     bn_ff, bn_in;
   logic              bfree_ff, bfree_in;
   logic              bdrop_ff, bdrop_in;
   logic              adrop_ff, adrop_in;
   logic [15:0]       book_symbol_ff, book_symbol_in;
   logic [SW-1:0]     free_head_ff, free_head_in;
   logic [SCW-1:0]    free_count_ff, free_count_in;
   logic [SCW-1:0]    fresh_ff, fresh_in;
   logic              bid_valid_ff, bid_valid_in;
   logic [LW-1:0]     bid_best_ff, bid_best_in;
   logic              ask_valid_ff, ask_valid_in;
   logic [LW-1:0]     ask_best_ff, ask_best_in;
   lobm_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // memory ports
   logic          qty_we, qty_re;
   logic [SW-1:0] qty_waddr, qty_raddr;
   logic [31:0]   qty_wdata, qty_rdata;
   logic          next_we, next_re;
   logic [SW-1:0] next_waddr, next_raddr;
   logic [SW-1:0] next_wdata, next_rdata;
   logic          bl_we, bl_re, al_we, al_re;
   logic [LW-1:0] bl_waddr, bl_raddr, al_waddr, al_raddr;
   lvl_type       bl_wdata, bl_rdata, al_wdata, al_rdata;

   lobm_pkg::bm_op_type bid_op, ask_op;
   logic [LW-1:0]       bid_tick, ask_tick;
   logic                bid_occ, ask_occ, bid_found, ask_found;
   logic [LW-1:0]       bid_found_tick, ask_found_tick;

   // working values
   logic          fresh;
   logic [SW-1:0] new_slot;
   logic [LW-1:0] p_new, p_ff;
   lvl_type       add_lvl, new_lvl;
   logic          add_occ;
   logic [40:0]   sum_total;
   logic [31:0]   m_trade;
   logic          m_bfree, m_afree;

   assign fresh    = (fresh_ff != SCW'(ORDER_SLOTS));
   assign new_slot = fresh ? SW'(fresh_ff) : free_head_ff;

   // saturate ticks beyond the top level
   assign p_new = (32'(req_payload.price_tick) >= PRICE_LEVELS) ? LW'(PRICE_LEVELS - 1)
                                                                 : LW'(req_payload.price_tick);
   assign p_ff  = (32'(req_ff.price_tick) >= PRICE_LEVELS) ? LW'(PRICE_LEVELS - 1)
                                                            : LW'(req_ff.price_tick);

   assign add_lvl   = (req_ff.side == lobm_pkg::SIDE_ASK) ? al_rdata : bl_rdata;
   assign add_occ   = (req_ff.side == lobm_pkg::SIDE_ASK) ? ask_occ : bid_occ;
   assign sum_total = {1'b0, add_lvl.total} + 41'(req_ff.quantity);

   assign m_trade = (bq_ff < qty_rdata) ? bq_ff : qty_rdata;
   assign m_bfree = (bq_ff == m_trade);
   assign m_afree = (qty_rdata == m_trade);

   always_comb begin
      new_lvl.head  = add_occ ? add_lvl.head : new_slot;
      new_lvl.tail  = new_slot;
      new_lvl.total = add_occ ? (sum_total[40] ? '1 : sum_total[39:0])
                              : 40'(req_ff.quantity);
   end

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      status_in      = status_ff;
      trade_in       = trade_ff;
      bq_in          = bq_ff;
      bn_in          = bn_ff;
      bfree_in       = bfree_ff;
      bdrop_in       = bdrop_ff;
      adrop_in       = adrop_ff;
      book_symbol_in = book_symbol_ff;
      free_head_in   = free_head_ff;
      free_count_in  = free_count_ff;
      fresh_in       = fresh_ff;
      bid_valid_in   = bid_valid_ff;
      bid_best_in    = bid_best_ff;
      ask_valid_in   = ask_valid_ff;
      ask_best_in    = ask_best_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      qty_we = 1'b0;  qty_waddr = '0;  qty_wdata = '0;
      qty_re = 1'b0;  qty_raddr = '0;
      next_we = 1'b0; next_waddr = '0; next_wdata = '0;
      next_re = 1'b0; next_raddr = '0;
      bl_we = 1'b0;   bl_waddr = '0;   bl_wdata = '0;
      bl_re = 1'b0;   bl_raddr = '0;
      al_we = 1'b0;   al_waddr = '0;   al_wdata = '0;
      al_re = 1'b0;   al_raddr = '0;
      bid_op = '0;    bid_tick = '0;
      ask_op = '0;    ask_tick = '0;

      if (csr_valid && state_ff == S_IDLE) begin
         book_symbol_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               trade_in = '0;
               if (req_payload.cmd == lobm_pkg::CMD_ADD) begin
                  if (req_payload.order_symbol != book_symbol_ff) begin
                     status_in = lobm_pkg::ST_WRONG;
                     state_in  = S_ORD;
                  end else if (free_count_ff == '0) begin
                     status_in = lobm_pkg::ST_FULL;
                     state_in  = S_ORD;
                  end else begin
                     // fetch the level, the free-list link and the occupancy bit
                     status_in  = lobm_pkg::ST_ADDED;
                     next_re    = 1'b1;
                     next_raddr = free_head_ff;
                     if (req_payload.side == lobm_pkg::SIDE_ASK) begin
                        al_re      = 1'b1;
                        al_raddr   = p_new;
                        ask_op.set = 1'b1;
                        ask_tick   = p_new;
                     end else begin
                        bl_re      = 1'b1;
                        bl_raddr   = p_new;
                        bid_op.set = 1'b1;
                        bid_tick   = p_new;
                     end
                     state_in = S_ADD;
                  end
               end else if (bid_valid_ff && ask_valid_ff && bid_best_ff >= ask_best_ff) begin
                  bl_re    = 1'b1;
                  bl_raddr = bid_best_ff;
                  al_re    = 1'b1;
                  al_raddr = ask_best_ff;
                  state_in = S_MT1;
               end else begin
                  status_in = lobm_pkg::ST_NO_CROSS;
                  state_in  = S_ORD;
               end
            end
         end

         S_ADD: begin
            // store the order, append it to its level, advance the allocator
            qty_we    = 1'b1;
            qty_waddr = new_slot;
            qty_wdata = req_ff.quantity;
            if (add_occ) begin
               next_we    = 1'b1;
               next_waddr = add_lvl.tail;
               next_wdata = new_slot;
            end
            if (req_ff.side == lobm_pkg::SIDE_ASK) begin
               al_we    = 1'b1;
               al_waddr = p_ff;
               al_wdata = new_lvl;
               if (!ask_valid_ff || p_ff < ask_best_ff) begin
                  ask_valid_in = 1'b1;
                  ask_best_in  = p_ff;
               end
            end else begin
               bl_we    = 1'b1;
               bl_waddr = p_ff;
               bl_wdata = new_lvl;
               if (!bid_valid_ff || p_ff > bid_best_ff) begin
                  bid_valid_in = 1'b1;
                  bid_best_in  = p_ff;
               end
            end
            if (fresh) begin
               fresh_in = fresh_ff + SCW'(1);
            end else begin
               free_head_in = next_rdata;
            end
            free_count_in = free_count_ff - SCW'(1);
            state_in      = S_ORD;
         end

         S_MT1: begin
            qty_re     = 1'b1;
            qty_raddr  = bl_rdata.head;
            next_re    = 1'b1;
            next_raddr = bl_rdata.head;
            state_in   = S_MT2;
         end

         S_MT2: begin
            bq_in      = qty_rdata;
            bn_in      = next_rdata;
            qty_re     = 1'b1;
            qty_raddr  = al_rdata.head;
            next_re    = 1'b1;
            next_raddr = al_rdata.head;
            state_in   = S_MT3;
         end

         S_MT3: begin
            // at most one front order survives the fill
            if (!m_bfree) begin
               qty_we    = 1'b1;
               qty_waddr = bl_rdata.head;
               qty_wdata = bq_ff - m_trade;
            end else if (!m_afree) begin
               qty_we    = 1'b1;
               qty_waddr = al_rdata.head;
               qty_wdata = qty_rdata - m_trade;
            end
            bl_we          = 1'b1;
            bl_waddr       = bid_best_ff;
            bl_wdata.head  = (m_bfree && bl_rdata.head != bl_rdata.tail) ? bn_ff
                                                                         : bl_rdata.head;
            bl_wdata.tail  = bl_rdata.tail;
            bl_wdata.total = (bl_rdata.total >= 40'(m_trade))
                             ? bl_rdata.total - 40'(m_trade) : '0;
            al_we          = 1'b1;
            al_waddr       = ask_best_ff;
            al_wdata.head  = (m_afree && al_rdata.head != al_rdata.tail) ? next_rdata
                                                                         : al_rdata.head;
            al_wdata.tail  = al_rdata.tail;
            al_wdata.total = (al_rdata.total >= 40'(m_trade))
                             ? al_rdata.total - 40'(m_trade) : '0;
            bdrop_in = m_bfree && (bl_rdata.head == bl_rdata.tail);
            adrop_in = m_afree && (al_rdata.head == al_rdata.tail);
            if (m_bfree && bl_rdata.head == bl_rdata.tail) begin
               bid_op.clr = 1'b1;
               bid_tick   = bid_best_ff;
            end
            if (m_afree && al_rdata.head == al_rdata.tail) begin
               ask_op.clr = 1'b1;
               ask_tick   = ask_best_ff;
            end
            // release the ask slot now, the bid slot next cycle
            if (m_afree) begin
               next_we       = 1'b1;
               next_waddr    = al_rdata.head;
               next_wdata    = free_head_ff;
               free_head_in  = al_rdata.head;
               free_count_in = free_count_ff + SCW'(1);
            end
            bfree_in  = m_bfree;
            trade_in  = m_trade;
            status_in = lobm_pkg::ST_TRADE;
            state_in  = S_MT4;
         end

         S_MT4: begin
            if (bfree_ff) begin
               next_we       = 1'b1;
               next_waddr    = bl_rdata.head;
               next_wdata    = free_head_ff;
               free_head_in  = bl_rdata.head;
               free_count_in = free_count_ff + SCW'(1);
            end
            state_in = (bdrop_ff || adrop_ff) ? S_SRCH : S_ORD;
         end

         S_SRCH: begin
            bid_op.search = bdrop_ff;
            ask_op.search = adrop_ff;
            state_in      = S_SRES;
         end

         S_SRES: begin
            if (bdrop_ff) begin
               bid_valid_in = bid_found;
               bid_best_in  = bid_found_tick;
            end
            if (adrop_ff) begin
               ask_valid_in = ask_found;
               ask_best_in  = ask_found_tick;
            end
            state_in = S_ORD;
         end

         S_ORD: begin
            bl_re    = 1'b1;
            bl_raddr = bid_best_ff;
            al_re    = 1'b1;
            al_raddr = ask_best_ff;
            state_in = S_OUT;
         end

         S_OUT: begin
            // hold while an earlier result is still stalled
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status        = status_ff;
               rsp_in.trade_qty     = trade_ff;
               rsp_in.bid_valid     = bid_valid_ff;
               rsp_in.best_bid      = bid_valid_ff ? 10'(bid_best_ff) : '0;
               rsp_in.ask_valid     = ask_valid_ff;
               rsp_in.best_ask      = ask_valid_ff ? 10'(ask_best_ff) : '0;
               rsp_in.bid_liquidity = bid_valid_ff ? bl_rdata.total : '0;
               rsp_in.ask_liquidity = ask_valid_ff ? al_rdata.total : '0;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         book_symbol_ff <= '0;
         free_head_ff   <= '0;
         free_count_ff  <= SCW'(ORDER_SLOTS);
         fresh_ff       <= '0;
         bid_valid_ff   <= 1'b0;
         bid_best_ff    <= '0;
         ask_valid_ff   <= 1'b0;
         ask_best_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         bfree_ff       <= 1'b0;
         bdrop_ff       <= 1'b0;
         adrop_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         book_symbol_ff <= book_symbol_in;
         free_head_ff   <= free_head_in;
         free_count_ff  <= free_count_in;
         fresh_ff       <= fresh_in;
         bid_valid_ff   <= bid_valid_in;
         bid_best_ff    <= bid_best_in;
         ask_valid_ff   <= ask_valid_in;
         ask_best_ff    <= ask_best_in;
         rsp_valid_ff   <= rsp_valid_in;
         bfree_ff       <= bfree_in;
         bdrop_ff       <= bdrop_in;
         adrop_ff       <= adrop_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      trade_ff  <= trade_in;
      bq_ff     <= bq_in;
      bn_ff     <= bn_in;
      rsp_ff    <= rsp_in;
   end

   // order quantities and free-list / queue links
   lobm_ram #(.DEPTH(ORDER_SLOTS), .WIDTH(32)) u_qty_ram (
      .clock (clock),
      .we    (qty_we),
      .waddr (qty_waddr),
      .wdata (qty_wdata),
      .re    (qty_re),
      .raddr (qty_raddr),
      .rdata (qty_rdata)
   );

   lobm_ram #(.DEPTH(ORDER_SLOTS), .WIDTH(SW)) u_next_ram (
      .clock (clock),
      .we    (next_we),
      .waddr (next_waddr),
      .wdata (next_wdata),
      .re    (next_re),
      .raddr (next_raddr),
      .rdata (next_rdata)
   );

   // per-level queue head, tail and resting total
   lobm_ram #(.DEPTH(PRICE_LEVELS), .WIDTH($bits(lvl_type))) u_bid_lvl_ram (
      .clock (clock),
      .we    (bl_we),
      .waddr (bl_waddr),
      .wdata (bl_wdata),
      .re    (bl_re),
      .raddr (bl_raddr),
      .rdata (bl_rdata)
   );

   lobm_ram #(.DEPTH(PRICE_LEVELS), .WIDTH($bits(lvl_type))) u_ask_lvl_ram (
      .clock (clock),
      .we    (al_we),
      .waddr (al_waddr),
      .wdata (al_wdata),
      .re    (al_re),
      .raddr (al_raddr),
      .rdata (al_rdata)
   );

   lobm_best #(.PRICE_LEVELS(PRICE_LEVELS), .HIGHEST(1'b1)) u_bid_best (
      .clock   (clock),
      .reset   (reset),
      .op_i    (bid_op),
      .tick_i  (bid_tick),
      .occ_o   (bid_occ),
      .found_o (bid_found),
      .best_o  (bid_found_tick)
   );

   lobm_best #(.PRICE_LEVELS(PRICE_LEVELS), .HIGHEST(1'b0)) u_ask_best (
      .clock   (clock),
      .reset   (reset),
      .op_i    (ask_op),
      .tick_i  (ask_tick),
      .occ_o   (ask_occ),
      .found_o (ask_found),
      .best_o  (ask_found_tick)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign csr_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // allocation never runs with an empty store
   `ASSERT_HOLDS(a_add_has_slot, clock, reset, state_ff == S_ADD |-> free_count_ff != '0)
   // released slots never exceed the store
   `ASSERT_NEVER(a_count_bound, clock, reset, free_count_ff > SCW'(ORDER_SLOTS))
   // a trade is only reported for a match request
   `ASSERT_HOLDS(a_trade_is_match, clock, reset,
      (state_ff == S_OUT && status_ff == lobm_pkg::ST_TRADE) |-> req_ff.cmd == lobm_pkg::CMD_MATCH)

endmodule

FILE: test/limit_order_book_matcher_test.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_test
// Self-checking bench for the order book matcher: a queued driver feeds add
// and match requests, a monitor compares every result against a behavioural
// book kept in the bench, under three idling regimes and several symbols.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_test;

   localparam int LEVELS = 1024;
   localparam int SLOTS  = 1024;
   localparam logic [39:0] TOTAL_CAP = 40'hFF_FFFF_FFFF;
   localparam int IDLE_LIMIT = 20000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   lobm_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   lobm_pkg::rsp_type rsp_payload;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [15:0]       csr_data = '0;

   limit_order_book_matcher i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow book
   logic [15:0] shadow_symbol;
   logic [31:0] slot_lots [SLOTS];
   int          slot_link [SLOTS];
   int          free_top;
   int          free_left;
   int          lvl_head  [2][LEVELS];
   int          lvl_tail  [2][LEVELS];
   logic [39:0] lvl_total [2][LEVELS];
   bit          lvl_live  [2][LEVELS];

   lobm_pkg::req_type pending_requests [$];
   lobm_pkg::rsp_type expected_results [$];
   int  errors = 0;
   int  sender_idle_pct = 0;
   int  receiver_idle_pct = 0;
   bit  hold_sender = 1'b0;
   int  quiet_cycles = 0;

   function automatic void book_clear();
      for (int i = 0; i < SLOTS; i++) begin
         slot_lots[i] = '0;
         slot_link[i] = (i + 1) % SLOTS;
      end
      free_top = 0;
      free_left = SLOTS;
      for (int s = 0; s < 2; s++)
         for (int p = 0; p < LEVELS; p++) begin
            lvl_head[s][p] = 0;
            lvl_tail[s][p] = 0;
            lvl_total[s][p] = '0;
            lvl_live[s][p] = 1'b0;
         end
   endfunction

   // best tick of a side: highest for bids, lowest for asks; -1 when empty
   function automatic int best_tick(int s);
      for (int i = 0; i < LEVELS; i++) begin
         int p;
         p = (s == 0) ? LEVELS - 1 - i : i;
         if (lvl_live[s][p]) return p;
      end
      return -1;
   endfunction

   function automatic void drop_front(int s, int p);
      int h;
      h = lvl_head[s][p];
      if (h == lvl_tail[s][p]) lvl_live[s][p] = 1'b0;
      else lvl_head[s][p] = slot_link[h];
      slot_link[h] = free_top;
      free_top = h;
      free_left++;
   endfunction

   function automatic lobm_pkg::rsp_type book_apply(lobm_pkg::req_type rq);
      lobm_pkg::rsp_type r;
      int      bb, ba, s, p, slot, bs, as_;
      logic [40:0] sum;
      logic [31:0] fill;
      r = '0;
      fill = '0;
      if (rq.cmd == lobm_pkg::CMD_ADD) begin
         if (rq.order_symbol != shadow_symbol) r.status = lobm_pkg::ST_WRONG;
         else if (free_left == 0) r.status = lobm_pkg::ST_FULL;
         else begin
            s = (rq.side == lobm_pkg::SIDE_ASK) ? 1 : 0;
            p = int'(rq.price_tick);
            slot = free_top;
            free_top = slot_link[slot];
            free_left--;
            slot_lots[slot] = rq.quantity;
            slot_link[slot] = slot;
            if (!lvl_live[s][p]) begin
               lvl_live[s][p] = 1'b1;
               lvl_head[s][p] = slot;
               lvl_tail[s][p] = slot;
               lvl_total[s][p] = {8'd0, rq.quantity};
            end else begin
               sum = {1'b0, lvl_total[s][p]} + {9'd0, rq.quantity};
               slot_link[lvl_tail[s][p]] = slot;
               lvl_tail[s][p] = slot;
               lvl_total[s][p] = sum[40] ? TOTAL_CAP : sum[39:0];
            end
            r.status = lobm_pkg::ST_ADDED;
         end
      end else begin
         r.status = lobm_pkg::ST_NO_CROSS;
         bb = best_tick(0);
         ba = best_tick(1);
         if (bb >= 0 && ba >= 0 && bb >= ba) begin
            bs = lvl_head[0][bb];
            as_ = lvl_head[1][ba];
            fill = (slot_lots[bs] < slot_lots[as_]) ? slot_lots[bs] : slot_lots[as_];
            slot_lots[bs] -= fill;
            slot_lots[as_] -= fill;
            lvl_total[1][ba] = (lvl_total[1][ba] >= fill) ? lvl_total[1][ba] - fill : '0;
            lvl_total[0][bb] = (lvl_total[0][bb] >= fill) ? lvl_total[0][bb] - fill : '0;
            if (slot_lots[as_] == 0) drop_front(1, ba);
            if (slot_lots[bs] == 0) drop_front(0, bb);
            r.status = lobm_pkg::ST_TRADE;
         end
      end
      r.trade_qty = fill;
      bb = best_tick(0);
      ba = best_tick(1);
      if (bb >= 0) begin
         r.bid_valid = 1'b1;
         r.best_bid = bb[9:0];
         r.bid_liquidity = lvl_total[0][bb];
      end
      if (ba >= 0) begin
         r.ask_valid = 1'b1;
         r.best_ask = ba[9:0];
         r.ask_liquidity = lvl_total[1][ba];
      end
      return r;
   endfunction

   // Driver: hold the payload while stalled, advance on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) expected_results.push_back(book_apply(req_payload));
         if (!hold_sender && pending_requests.size() > 0 &&
             $urandom_range(99) >= sender_idle_pct) begin
            req_payload <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      lobm_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_payload);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload !== want) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, rsp_payload);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // Watchdog: count cycles in which no request, result or write is taken.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic lobm_pkg::req_type make_add(logic [15:0] sym, logic sd, logic [9:0] tick,
                                                  logic [31:0] lots);
      lobm_pkg::req_type rq;
      rq.cmd = lobm_pkg::CMD_ADD;
      rq.order_symbol = sym;
      rq.side = sd;
      rq.price_tick = tick;
      rq.quantity = lots;
      return rq;
   endfunction

   function automatic lobm_pkg::req_type make_match();
      lobm_pkg::req_type rq;
      rq = '0;
      rq.cmd = lobm_pkg::CMD_MATCH;
      rq.order_symbol = 16'($urandom);
      rq.price_tick = 10'($urandom);
      rq.quantity = $urandom;
      rq.side = 1'($urandom);
      return rq;
   endfunction

   // Wait until the bench is drained, then let the block settle.
   task automatic drain();
      while (pending_requests.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_symbol(logic [15:0] sym);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= sym;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_symbol = sym;
   endtask

   // Random lots: mostly small so trades interleave, sometimes huge.
   function automatic logic [31:0] pick_lots();
      case ($urandom_range(9))
         0: return 32'hFFFF_FFFF - $urandom_range(3);
         1: return $urandom;
         2: return 32'd0;
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   task automatic queue_random(int count, logic [15:0] sym, int centre);
      int  dice;
      logic [9:0] tick;
      for (int i = 0; i < count; i++) begin
         dice = $urandom_range(99);
         tick = 10'((centre + $urandom_range(12) - 6) & 10'h3FF);
         if (dice < 45)
            pending_requests.push_back(make_add(sym, 1'($urandom), tick, pick_lots()));
         else if (dice < 50)
            pending_requests.push_back(make_add(16'($urandom), 1'($urandom),
                                                10'($urandom), $urandom));
         else if (dice < 53)
            pending_requests.push_back(make_add(sym, 1'($urandom), 10'($urandom),
                                                pick_lots()));
         else
            pending_requests.push_back(make_match());
      end
   endtask

   initial begin
      book_clear();
      shadow_symbol = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset symbol, extreme ticks and lots, wrong symbol,
      // empty-side and uncrossed matches, zero lots, total saturation.
      sender_idle_pct = 26;
      receiver_idle_pct = 54;
      pending_requests.push_back(make_match());
      pending_requests.push_back(make_add(16'hFFFF, lobm_pkg::SIDE_BID, 10'd5, 32'd7));
      pending_requests.push_back(make_add(16'h0000, lobm_pkg::SIDE_BID, 10'd0, 32'd1));
      pending_requests.push_back(make_match());
      pending_requests.push_back(make_add(16'h0000, lobm_pkg::SIDE_ASK, 10'h3FF,
                                          32'hFFFF_FFFF));
      pending_requests.push_back(make_match());
      pending_requests.push_back(make_add(16'h0000, lobm_pkg::SIDE_ASK, 10'd0, 32'd0));
      pending_requests.push_back(make_match());
      pending_requests.push_back(make_add(16'h0000, lobm_pkg::SIDE_BID, 10'h3FF,
                                          32'hFFFF_FFFF));
      pending_requests.push_back(make_add(16'h0000, lobm_pkg::SIDE_BID, 10'h3FF,
                                          32'hFFFF_FFFF));
      for (int i = 0; i < 260; i++)
         pending_requests.push_back(make_add(16'h0000, lobm_pkg::SIDE_BID, 10'h3FF,
                                             32'hFFFF_FFFF));
      for (int i = 0; i < 8; i++) pending_requests.push_back(make_match());
      pending_requests.push_back(make_add(16'h0000, lobm_pkg::SIDE_ASK, 10'd100, 32'd3));
      pending_requests.push_back(make_add(16'h0000, lobm_pkg::SIDE_ASK, 10'd100, 32'd4));
      for (int i = 0; i < 3; i++) pending_requests.push_back(make_match());
      drain();

      // Fill the order store on a fresh symbol, then hit store full; about
      // 260 orders already rest in the book from the directed part.
      write_symbol(16'hFFFF);
      for (int i = 0; i < SLOTS - 244; i++)
         pending_requests.push_back(make_add(16'hFFFF, 1'(i & 1),
            (i & 1) ? 10'd900 : 10'd10, $urandom_range(1, 9)));
      for (int i = 0; i < 40; i++) pending_requests.push_back(make_match());
      drain();

      // Hold the sender until every result has arrived, then resume.
      queue_random(60, 16'hFFFF, 500);
      wait (pending_requests.size() < 30);
      hold_sender = 1'b1;
      while (req_valid || expected_results.size() > 0) @(posedge clock);
      hold_sender = 1'b0;
      drain();

      sender_idle_pct = 54;
      receiver_idle_pct = 26;
      write_symbol(16'h5A3C);
      queue_random(100, 16'h5A3C, 300);
      drain();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_symbol(16'h0000);
      queue_random(100, 16'h0000, 700);
      drain();

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+hdl
hdl/lobm_pkg.sv
hdl/lobm_ram.sv
hdl/lobm_best.sv
hdl/limit_order_book_matcher.sv
test/limit_order_book_matcher_test.sv
